/* hw/rtl/rmq_pkg.sv */
// Shared types and codes for the rotation matrix to quaternion core.
// No dependencies.
`default_nettype none
package rmq_pkg;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_M00   = 2'd1,
		BR_M11   = 2'd2,
		BR_M22   = 2'd3
	} branch_t;

	// control that travels beside the datapath
	typedef struct packed {
		branch_t br;
		logic    deg;
		logic    neg_d;  // sign of the diagonal component
		logic    neg0;
		logic    neg1;
		logic    neg2;
	} side_t;

endpackage
`default_nettype wire

/* hw/rtl/rmq_div_pipe.sv */
// Restoring divider, one quotient bit per stage, quotient capped to 2*DW bits.
// Pure datapath with a common enable; no package use.
`default_nettype none
module rmq_div_pipe #(
	parameter int DW = 16,
	parameter int NW = 46,
	parameter int RW = 21
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [NW-1:0]   num,
	input  wire logic [RW-1:0]   den,
	output logic      [2*DW-1:0] quot
);
	localparam int QW = 2 * DW;
	localparam int HW = NW - QW;
	localparam int CW = (HW > RW) ? HW : RW;

	logic [RW:0]   rem_s [0:QW];
	logic [QW-1:0] low_s [0:QW];
	logic [QW-1:0] q_s   [0:QW];
	logic [RW-1:0] den_s [0:QW];
	logic          ovf_s [0:QW];

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= CW'(num[NW-1:QW]) >= CW'(den);
			rem_s[0] <= (RW+1)'(num[NW-1:QW]);
			low_s[0] <= num[QW-1:0];
			q_s[0]   <= '0;
			den_s[0] <= den;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [RW:0] trial;
		logic        ge;
		assign trial = {rem_s[i][RW-1:0], low_s[i][QW-1]};
		assign ge    = trial >= {1'b0, den_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? (trial - {1'b0, den_s[i]}) : trial;
				low_s[i+1] <= {low_s[i][QW-2:0], 1'b0};
				q_s[i+1]   <= {q_s[i][QW-2:0], ge};
				den_s[i+1] <= den_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	assign quot = ovf_s[QW] ? '1 : q_s[QW];

endmodule
`default_nettype wire

/* hw/rtl/rmq_sqrt_pipe.sv */
// Integer square root, one result bit per stage, then (root + 1) / 2.
// Pure datapath with a common enable; no package use.
`default_nettype none
module rmq_sqrt_pipe #(
	parameter int DW = 16
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [2*DW-1:0] n,
	output logic      [DW-1:0]   half
);
	logic [DW+1:0]   rem_s  [0:DW];
	logic [DW-1:0]   root_s [0:DW];
	logic [2*DW-1:0] bits_s [0:DW];
	logic [DW:0]     inc;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			bits_s[0] <= n;
		end
	end

	for (genvar i = 0; i < DW; i++) begin : g_step
		logic [DW+1:0] cur, trial;
		logic          ge;
		assign cur   = {rem_s[i][DW-1:0], bits_s[i][2*DW-1 -: 2]};
		assign trial = {root_s[i], 2'b01};
		assign ge    = cur >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? (cur - trial) : cur;
				root_s[i+1] <= {root_s[i][DW-2:0], ge};
				bits_s[i+1] <= {bits_s[i][2*DW-3:0], 2'b00};
			end
		end
	end

	// round half away: sqrt/2 rounded
	assign inc  = {1'b0, root_s[DW]} + (DW+1)'(1);
	assign half = inc[DW:1];

endmodule
`default_nettype wire

/* hw/rtl/rotation_matrix_to_quaternion_core.sv */
// Top level: rotation matrix (Q1.F) to quaternion, Shepperd four-way branch.
// Uses rmq_pkg, rmq_div_pipe and rmq_sqrt_pipe.
//
//  channel  | direction | tdata                          | tuser
//  s_axis   | in        | m00..m22, DW bits each         | -
//  m_axis   | out       | quat_w, quat_x, quat_y, quat_z | branch_taken, degenerate
//
// The pipe runs through S1, S2, the bit-per-stage divider and square root,
// and the output register. One request per cycle while m_axis is not stalled.
// Stalls freeze the whole pipe; s_axis_tready drops only while a result
// waits in the output register. Reset clears the valid bits.
`default_nettype none
module rotation_matrix_to_quaternion_core #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 14
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// m00 m01 m02 m10 m11 m12 m20 m21 m22, low bits first
	input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// quat_w quat_x quat_y quat_z, low bits first
	output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// branch_taken [1:0], degenerate [2]
	output logic [2:0] m_axis_tuser
);
	localparam int DW  = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int OW  = ((4*DW+7)/8)*8;
	localparam int QW  = 2 * DW;
	localparam int RW  = ((DW > F+1) ? DW : F+1) + 3;
	localparam int AW  = DW + 1;
	localparam int NW  = 2*AW + F;
	localparam int NDW = RW + F;
	localparam int XW  = NDW + QW;
	localparam int LS  = QW + DW + 2;
	localparam int LN  = QW + 1;
	localparam logic signed [RW-1:0] ONE = RW'(1) << F;

	logic adv;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// ---- S1: trace, branch choice, radicand, off-diagonal terms
	logic signed [DW-1:0] m [0:8];
	for (genvar k = 0; k < 9; k++) begin : g_unpack
		assign m[k] = s_axis_tdata[k*DW +: DW];
	end

	logic signed [RW-1:0] m00, m11, m22, t, r_c;
	logic signed [DW:0]   d0_c, d1_c, d2_c;
	rmq_pkg::branch_t     br_c;
	assign m00 = RW'(m[0]);
	assign m11 = RW'(m[4]);
	assign m22 = RW'(m[8]);
	assign t   = m00 + m11 + m22;

	always_comb begin
		priority if (t > 0) begin
			br_c = rmq_pkg::BR_TRACE;
			r_c  = ONE + t;
		end else if (m00 > m11 && m00 > m22) begin
			br_c = rmq_pkg::BR_M00;
			r_c  = ONE + m00 - m11 - m22;
		end else if (m11 > m22) begin
			br_c = rmq_pkg::BR_M11;
			r_c  = ONE + m11 - m00 - m22;
		end else begin
			br_c = rmq_pkg::BR_M22;
			r_c  = ONE + m22 - m00 - m11;
		end
	end

	// off-diagonal terms in the order each branch lists them
	always_comb begin
		unique case (br_c)
			rmq_pkg::BR_TRACE: begin
				d0_c = (DW+1)'(m[7]) - (DW+1)'(m[5]);
				d1_c = (DW+1)'(m[2]) - (DW+1)'(m[6]);
				d2_c = (DW+1)'(m[3]) - (DW+1)'(m[1]);
			end
			rmq_pkg::BR_M00: begin
				d0_c = (DW+1)'(m[1]) + (DW+1)'(m[3]);
				d1_c = (DW+1)'(m[2]) + (DW+1)'(m[6]);
				d2_c = (DW+1)'(m[7]) - (DW+1)'(m[5]);
			end
			rmq_pkg::BR_M11: begin
				d0_c = (DW+1)'(m[1]) + (DW+1)'(m[3]);
				d1_c = (DW+1)'(m[5]) + (DW+1)'(m[7]);
				d2_c = (DW+1)'(m[2]) - (DW+1)'(m[6]);
			end
			default: begin
				d0_c = (DW+1)'(m[2]) + (DW+1)'(m[6]);
				d1_c = (DW+1)'(m[5]) + (DW+1)'(m[7]);
				d2_c = (DW+1)'(m[3]) - (DW+1)'(m[1]);
			end
		endcase
	end

	logic                 vld_s1;
	rmq_pkg::branch_t     br_s1;
	logic signed [RW-1:0] r_s1;
	logic signed [DW:0]   d_s1 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			br_s1   <= br_c;
			r_s1    <= r_c;
			d_s1[0] <= d0_c;
			d_s1[1] <= d1_c;
			d_s1[2] <= d2_c;
		end
	end

	// ---- S2: squares, divisor, diagonal radicand
	logic          neg_s_c, deg_c;
	logic [NDW-1:0] rs_c;
	logic [AW-1:0] a_c [0:2];
	assign neg_s_c = br_s1 != rmq_pkg::BR_TRACE;
	assign deg_c   = r_s1 <= 0;
	assign rs_c    = NDW'(r_s1[RW-2:0]) << F;
	for (genvar k = 0; k < 3; k++) begin : g_abs
		assign a_c[k] = d_s1[k][DW] ? AW'(-d_s1[k]) : AW'(d_s1[k]);
	end

	logic           vld_s2;
	rmq_pkg::side_t side_s2;
	logic [NW-1:0]  num_s2 [0:2];
	logic [RW-1:0]  den_s2;
	logic [QW-1:0]  ndiag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2.br    <= br_s1;
			side_s2.deg   <= deg_c;
			side_s2.neg_d <= neg_s_c;
			side_s2.neg0  <= d_s1[0][DW] != neg_s_c;
			side_s2.neg1  <= d_s1[1][DW] != neg_s_c;
			side_s2.neg2  <= d_s1[2][DW] != neg_s_c;
			for (int k = 0; k < 3; k++) begin
				num_s2[k] <= NW'({(2*AW)'(a_c[k]) * (2*AW)'(a_c[k]), {F{1'b0}}});
			end
			den_s2   <= deg_c ? RW'(1) : r_s1;
			ndiag_s2 <= (XW'(rs_c) > XW'({QW{1'b1}})) ? '1 : QW'(rs_c);
		end
	end

	// ---- divide and square-root lanes
	logic [QW-1:0] quot [0:2];
	logic [DW-1:0] half [0:3];

	for (genvar k = 0; k < 3; k++) begin : g_div
		rmq_div_pipe #(.DW(DW), .NW(NW), .RW(RW)) u_div (
			.clk  (clk),
			.en   (adv),
			.num  (num_s2[k]),
			.den  (den_s2),
			.quot (quot[k])
		);
		rmq_sqrt_pipe #(.DW(DW)) u_sqrt (
			.clk  (clk),
			.en   (adv),
			.n    (quot[k]),
			.half (half[k])
		);
	end

	// diagonal radicand waits out the divider
	logic [QW-1:0] nd_s [1:LN];
	always_ff @(posedge clk) begin
		if (adv) begin
			nd_s[1] <= ndiag_s2;
			for (int k = 2; k <= LN; k++) begin
				nd_s[k] <= nd_s[k-1];
			end
		end
	end

	rmq_sqrt_pipe #(.DW(DW)) u_sqrt_diag (
		.clk  (clk),
		.en   (adv),
		.n    (nd_s[LN]),
		.half (half[3])
	);

	logic           vld_s  [1:LS];
	rmq_pkg::side_t side_s [1:LS];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= vld_s2;
			for (int k = 2; k <= LS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= side_s2;
			for (int k = 2; k <= LS; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// ---- saturate, place components, output register
	function automatic logic [DW-1:0] sat(input logic [DW-1:0] mag, input logic neg);
		logic big;
		big = mag[DW-1];
		if (neg) begin
			sat = big ? {1'b1, {(DW-1){1'b0}}} : DW'(-mag);
		end else begin
			sat = big ? {1'b0, {(DW-1){1'b1}}} : mag;
		end
	endfunction

	rmq_pkg::side_t sd;
	logic [DW-1:0]  g, o0, o1, o2;
	logic [DW-1:0]  qw_c, qx_c, qy_c, qz_c;
	assign sd = side_s[LS];
	assign g  = sat(half[3], sd.neg_d);
	assign o0 = sat(half[0], sd.neg0);
	assign o1 = sat(half[1], sd.neg1);
	assign o2 = sat(half[2], sd.neg2);

	always_comb begin
		unique case (sd.br)
			rmq_pkg::BR_TRACE: begin
				qw_c = g;  qx_c = o0; qy_c = o1; qz_c = o2;
			end
			rmq_pkg::BR_M00: begin
				qx_c = g;  qy_c = o0; qz_c = o1; qw_c = o2;
			end
			rmq_pkg::BR_M11: begin
				qy_c = g;  qx_c = o0; qz_c = o1; qw_c = o2;
			end
			default: begin
				qz_c = g;  qx_c = o0; qy_c = o1; qw_c = o2;
			end
		endcase
	end

	logic [4*DW-1:0] quat_out_q;
	logic [2:0]      user_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= vld_s[LS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quat_out_q <= sd.deg ? '0 : {qz_c, qy_c, qx_c, qw_c};
			user_out_q <= {sd.deg, sd.br};
		end
	end

	assign m_axis_tdata = OW'(quat_out_q);
	assign m_axis_tuser = user_out_q;

	// ---- checks
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata == '0)
		else $error("degenerate result with nonzero quaternion");

	a_trace_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[2] && m_axis_tuser[1:0] == rmq_pkg::BR_TRACE
		|-> !m_axis_tdata[DW-1])
		else $error("trace branch gave negative w");

	a_m00_x_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[2] && m_axis_tuser[1:0] == rmq_pkg::BR_M00
		|-> m_axis_tdata[2*DW-1] || m_axis_tdata[2*DW-1:DW] == '0)
		else $error("m00 branch gave positive x");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a waiting result");

endmodule
`default_nettype wire
